// ===== design/bfp_pkg.sv =====
// bitmap font text parser: shared types, codes and keyword tables
// used by bfp_front, bfp_queue, bfp_back and the top level
`default_nettype none

package bfp_pkg;

  // character classes worked out in the front part
  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_MINUS,
    CLS_SPACE,
    CLS_NEWLINE,
    CLS_OTHER
  } char_cls_e;

  // one classified byte as it sits in the queue
  typedef struct packed {
    logic [7:0] text_byte;
    logic       start;
    char_cls_e  cls;
    logic       hex_ok;
    logic [3:0] hex_val;
  } bfp_item_t;

  typedef enum logic [2:0] {
    M_TOKEN,
    M_SKIP,
    M_NUM,
    M_NUM_TAIL,
    M_ROW_HI,
    M_ROW_LO,
    M_ROW_SEP
  } parse_mode_e;

  typedef enum logic [3:0] {
    KIND_PT_SIZE = 4'd0,
    KIND_DPI_X   = 4'd1,
    KIND_DPI_Y   = 4'd2,
    KIND_BOX_W   = 4'd3,
    KIND_BOX_H   = 4'd4,
    KIND_BOX_X   = 4'd5,
    KIND_BOX_Y   = 4'd6,
    KIND_ROW     = 4'd7,
    KIND_BAD_HEX = 4'd8
  } field_kind_e;

  typedef enum logic [1:0] {
    KW_SIZE   = 2'd0,
    KW_BOX    = 2'd1,
    KW_BITMAP = 2'd2
  } kw_e;

  localparam logic [8*4-1:0]  KwSizeStr   = "SIZE";
  localparam logic [8*15-1:0] KwBoxStr    = "FONTBOUNDINGBOX";
  localparam logic [8*6-1:0]  KwBitmapStr = "BITMAP";
  localparam logic [4:0]      KwSizeLen   = 5'd4;
  localparam logic [4:0]      KwBoxLen    = 5'd15;
  localparam logic [4:0]      KwBitmapLen = 5'd6;
  localparam logic [4:0]      TokLenMax   = 5'd31;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChMinus   = 8'h2D;

  localparam logic [31:0] MagLimit = 32'h8000_0000;
  localparam logic [31:0] ValueMax = 32'h7FFF_FFFF;

  localparam int QDepth = 2;

  // true when byte c matches keyword k at position pos
  function automatic logic kw_hit(input kw_e k, input logic [4:0] pos,
                                  input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    unique case (k)
      KW_SIZE:   if (pos < KwSizeLen) begin
        hit = (KwSizeStr[8*(3 - int'(pos)) +: 8] == c);
      end
      KW_BOX:    if (pos < KwBoxLen) begin
        hit = (KwBoxStr[8*(14 - int'(pos)) +: 8] == c);
      end
      KW_BITMAP: if (pos < KwBitmapLen) begin
        hit = (KwBitmapStr[8*(5 - int'(pos)) +: 8] == c);
      end
      default:   hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== design/bfp_front.sv =====
// front part: classifies each incoming text byte for the parser
// depends on bfp_pkg
`default_nettype none

module bfp_front (
  input  wire logic [7:0]        text_byte_i,
  input  wire logic              start_i,
  output bfp_pkg::bfp_item_t     item_o
);
  import bfp_pkg::*;

  always_comb begin
    item_o.text_byte = text_byte_i;
    item_o.start     = start_i;
    item_o.hex_ok    = 1'b0;
    item_o.hex_val   = 4'd0;
    if (text_byte_i >= 8'h30 && text_byte_i <= 8'h39) begin
      item_o.hex_ok  = 1'b1;
      item_o.hex_val = 4'(text_byte_i - 8'h30);
    end else if (text_byte_i >= 8'h41 && text_byte_i <= 8'h46) begin
      item_o.hex_ok  = 1'b1;
      item_o.hex_val = 4'(text_byte_i - 8'h37);
    end

    if (text_byte_i >= 8'h30 && text_byte_i <= 8'h39) begin
      item_o.cls = CLS_DIGIT;
    end else if (text_byte_i == ChMinus) begin
      item_o.cls = CLS_MINUS;
    end else if (text_byte_i == ChSpace) begin
      item_o.cls = CLS_SPACE;
    end else if (text_byte_i == ChNewline) begin
      item_o.cls = CLS_NEWLINE;
    end else begin
      item_o.cls = CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

// ===== design/bfp_queue.sv =====
// short queue of classified bytes between front and back parts
// depends on bfp_pkg
`default_nettype none

module bfp_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_valid_i,
  output logic                    wr_ready_o,
  input  wire bfp_pkg::bfp_item_t wr_item_i,
  output logic                    rd_valid_o,
  input  wire logic               rd_ready_i,
  output bfp_pkg::bfp_item_t      rd_item_o
);
  import bfp_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QDepth);

  bfp_item_t       entry_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign wr_ready_o = (count_q != FullCnt);
  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = entry_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= wr_item_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt) else $error("queue count beyond depth");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a push");
  a_head_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_o && !rd_ready_i) |=> $stable(rd_ptr_q))
    else $error("queue head moved without a pop");
`endif

endmodule

`default_nettype wire

// ===== design/bfp_back.sv =====
// back part: line, number and bitmap parser with registered result beat
// depends on bfp_pkg
`default_nettype none

module bfp_back #(
  parameter int MAX_GLYPHS = 128,
  parameter int MAX_ROWS   = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  output logic                    item_ready_o,
  input  wire bfp_pkg::bfp_item_t item_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output logic [3:0]              res_kind_o,
  output logic [31:0]             res_value_o,
  output logic [6:0]              res_glyph_o,
  output logic [4:0]              res_row_o,
  output logic                    res_full_o
);
  import bfp_pkg::*;

  localparam int GW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam logic [GW-1:0] LastGlyph = GW'(MAX_GLYPHS - 1);
  localparam logic [RW-1:0] MaxRowsV  = RW'(MAX_ROWS);

  parse_mode_e   mode_q, mode_d, cur_mode;
  logic [2:0]    kw_q, kw_d, cur_kw;
  logic [4:0]    tl_q, tl_d, cur_tl;
  logic [31:0]   acc_q, acc_d, cur_acc;
  logic          neg_q, neg_d, cur_neg;
  logic [2:0]    fp_q, fp_d, cur_fp;
  logic [RW-1:0] rpg_q, rpg_d, cur_rpg;
  logic [RW-1:0] rc_q, rc_d, cur_rc;
  logic [GW-1:0] gc_q, gc_d, cur_gc;
  logic [3:0]    hn_q, hn_d, cur_hn;
  logic          hb_q, hb_d, cur_hb;
  logic          done_q, done_d, cur_done;

  logic          out_valid_q;
  logic [3:0]    out_kind_q;
  logic [31:0]   out_value_q;
  logic [6:0]    out_glyph_q;
  logic [4:0]    out_row_q;
  logic          out_full_q;

  logic          pop;
  logic          emit_c;
  field_kind_e   kind_c;
  logic [31:0]   value_c;
  logic [6:0]    glyph_c;
  logic [4:0]    row_c;
  logic          full_c;

  logic          is_sep, is_nl, is_int;
  logic [35:0]   prod;
  logic [31:0]   acc_next;
  logic [31:0]   num_value;
  logic [RW:0]   rc_inc;
  logic          rows_end;
  logic          last_glyph;
  logic [4:0]    tl_inc;
  logic [GW+6:0] glyph_ext;
  logic [RW+4:0] row_ext;
  logic [RW-1:0] rpg_num;

  assign item_ready_o = !out_valid_q || res_ready_i;
  assign pop          = item_valid_i && item_ready_o;

  // start of font restarts every piece of state before the byte is handled
  always_comb begin
    if (item_i.start) begin
      cur_mode = M_TOKEN;
      cur_kw   = 3'b111;
      cur_tl   = '0;
      cur_acc  = '0;
      cur_neg  = 1'b0;
      cur_fp   = '0;
      cur_rpg  = '0;
      cur_rc   = '0;
      cur_gc   = '0;
      cur_hn   = '0;
      cur_hb   = 1'b0;
      cur_done = 1'b0;
    end else begin
      cur_mode = mode_q;
      cur_kw   = kw_q;
      cur_tl   = tl_q;
      cur_acc  = acc_q;
      cur_neg  = neg_q;
      cur_fp   = fp_q;
      cur_rpg  = rpg_q;
      cur_rc   = rc_q;
      cur_gc   = gc_q;
      cur_hn   = hn_q;
      cur_hb   = hb_q;
      cur_done = done_q;
    end
  end

  always_comb begin
    is_nl      = (item_i.cls == CLS_NEWLINE);
    is_sep     = is_nl || (item_i.cls == CLS_SPACE);
    is_int     = (item_i.cls == CLS_DIGIT) || (item_i.cls == CLS_MINUS);
    prod       = ({4'b0, cur_acc} << 3) + ({4'b0, cur_acc} << 1) + {32'b0, item_i.hex_val};
    acc_next   = (prod > {4'b0, MagLimit}) ? MagLimit : prod[31:0];
    num_value  = cur_neg ? (32'd0 - cur_acc) : ((cur_acc > ValueMax) ? ValueMax : cur_acc);
    rc_inc     = {1'b0, cur_rc} + 1'b1;
    rows_end   = (rc_inc >= {1'b0, cur_rpg});
    last_glyph = (cur_gc >= LastGlyph);
    tl_inc     = (cur_tl < TokLenMax) ? cur_tl + 1'b1 : cur_tl;
    glyph_ext  = {7'b0, cur_gc};
    row_ext    = {5'b0, cur_rc};
    if (cur_neg && cur_acc != '0) begin
      rpg_num = MaxRowsV;
    end else if (cur_acc > 32'(MAX_ROWS)) begin
      rpg_num = MaxRowsV;
    end else begin
      rpg_num = cur_acc[RW-1:0];
    end
  end

  // next state
  always_comb begin
    mode_d = cur_mode;
    kw_d   = cur_kw;
    tl_d   = cur_tl;
    acc_d  = cur_acc;
    neg_d  = cur_neg;
    fp_d   = cur_fp;
    rpg_d  = cur_rpg;
    rc_d   = cur_rc;
    gc_d   = cur_gc;
    hn_d   = cur_hn;
    hb_d   = cur_hb;
    done_d = cur_done;
    if (!cur_done) begin
      unique case (cur_mode)
        M_TOKEN: begin
          if (is_sep) begin
            if (cur_kw[KW_SIZE] && cur_tl == KwSizeLen) begin
              fp_d   = 3'(KIND_PT_SIZE);
              mode_d = M_NUM;
              acc_d  = '0;
              neg_d  = 1'b0;
              tl_d   = '0;
            end else if (cur_kw[KW_BOX] && cur_tl == KwBoxLen) begin
              fp_d   = 3'(KIND_BOX_W);
              mode_d = M_NUM;
              acc_d  = '0;
              neg_d  = 1'b0;
              tl_d   = '0;
            end else if (cur_kw[KW_BITMAP] && cur_tl == KwBitmapLen) begin
              rc_d = '0;
              if (cur_rpg == '0) begin
                mode_d = M_SKIP;
                if (last_glyph) begin
                  done_d = 1'b1;
                end else begin
                  gc_d = cur_gc + 1'b1;
                end
              end else begin
                mode_d = M_ROW_HI;
              end
            end else if (is_nl) begin
              mode_d = M_TOKEN;
              kw_d   = 3'b111;
              tl_d   = '0;
            end else begin
              mode_d = M_SKIP;
            end
          end else begin
            kw_d[KW_SIZE]   = cur_kw[KW_SIZE] && kw_hit(KW_SIZE, cur_tl, item_i.text_byte);
            kw_d[KW_BOX]    = cur_kw[KW_BOX] && kw_hit(KW_BOX, cur_tl, item_i.text_byte);
            kw_d[KW_BITMAP] = cur_kw[KW_BITMAP]
                              && kw_hit(KW_BITMAP, cur_tl, item_i.text_byte);
            tl_d            = tl_inc;
          end
        end
        M_NUM, M_NUM_TAIL: begin
          if (is_int) begin
            if (cur_mode == M_NUM) begin
              if (item_i.cls == CLS_MINUS) begin
                if (cur_tl == '0) begin
                  neg_d = 1'b1;
                end else begin
                  mode_d = M_NUM_TAIL;
                end
              end else begin
                acc_d = acc_next;
              end
            end
            tl_d = tl_inc;
          end else begin
            if (cur_fp == 3'(KIND_PT_SIZE)) begin
              rpg_d = rpg_num;
            end
            if (cur_fp == 3'(KIND_DPI_Y) || cur_fp >= 3'(KIND_BOX_Y)) begin
              if (is_nl) begin
                mode_d = M_TOKEN;
                kw_d   = 3'b111;
                tl_d   = '0;
              end else begin
                mode_d = M_SKIP;
              end
            end else begin
              fp_d   = cur_fp + 1'b1;
              mode_d = M_NUM;
              acc_d  = '0;
              neg_d  = 1'b0;
              tl_d   = '0;
            end
          end
        end
        M_ROW_HI: begin
          hb_d   = !item_i.hex_ok;
          hn_d   = item_i.hex_ok ? item_i.hex_val : 4'd0;
          mode_d = M_ROW_LO;
        end
        M_ROW_LO: begin
          rc_d   = rc_inc[RW-1:0];
          mode_d = M_ROW_SEP;
          if (rows_end) begin
            if (last_glyph) begin
              done_d = 1'b1;
            end else begin
              gc_d = cur_gc + 1'b1;
            end
          end
        end
        M_ROW_SEP: begin
          mode_d = (cur_rc >= cur_rpg) ? M_SKIP : M_ROW_HI;
        end
        M_SKIP: begin
          if (is_nl) begin
            mode_d = M_TOKEN;
            kw_d   = 3'b111;
            tl_d   = '0;
          end
        end
        default: begin
          mode_d = M_SKIP;
        end
      endcase
    end
  end

  // result beat
  always_comb begin
    emit_c  = 1'b0;
    kind_c  = KIND_ROW;
    value_c = '0;
    glyph_c = '0;
    row_c   = '0;
    full_c  = 1'b0;
    if (!cur_done) begin
      unique case (cur_mode)
        M_NUM, M_NUM_TAIL: begin
          if (!is_int) begin
            emit_c  = 1'b1;
            kind_c  = field_kind_e'({1'b0, cur_fp});
            value_c = num_value;
          end
        end
        M_ROW_LO: begin
          emit_c  = 1'b1;
          glyph_c = glyph_ext[6:0];
          row_c   = row_ext[4:0];
          full_c  = rows_end && last_glyph;
          if (cur_hb || !item_i.hex_ok) begin
            kind_c = KIND_BAD_HEX;
          end else begin
            kind_c  = KIND_ROW;
            value_c = {24'b0, cur_hn, item_i.hex_val};
          end
        end
        M_TOKEN, M_ROW_HI, M_ROW_SEP, M_SKIP: begin
          emit_c = 1'b0;
        end
        default: begin
          emit_c = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= M_TOKEN;
      kw_q        <= 3'b111;
      tl_q        <= '0;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      fp_q        <= '0;
      rpg_q       <= '0;
      rc_q        <= '0;
      gc_q        <= '0;
      hn_q        <= '0;
      hb_q        <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        mode_q <= mode_d;
        kw_q   <= kw_d;
        tl_q   <= tl_d;
        acc_q  <= acc_d;
        neg_q  <= neg_d;
        fp_q   <= fp_d;
        rpg_q  <= rpg_d;
        rc_q   <= rc_d;
        gc_q   <= gc_d;
        hn_q   <= hn_d;
        hb_q   <= hb_d;
        done_q <= done_d;
      end
      out_valid_q <= pop ? emit_c : (out_valid_q && !res_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit_c) begin
      out_kind_q  <= kind_c;
      out_value_q <= value_c;
      out_glyph_q <= glyph_c;
      out_row_q   <= row_c;
      out_full_q  <= full_c;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_kind_o  = out_kind_q;
  assign res_value_o = out_value_q;
  assign res_glyph_o = out_glyph_q;
  assign res_row_o   = out_row_q;
  assign res_full_o  = out_full_q;

`ifndef ASSERT_OFF
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && done_q && !item_i.start) |=> !res_valid_o)
    else $error("result produced after the last glyph");
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_ROW_HI || mode_q == M_ROW_LO || mode_q == M_ROW_SEP)
    |-> (rc_q <= rpg_q)) else $error("row counter past rows per glyph");
  a_glyph_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gc_q <= LastGlyph) else $error("glyph counter past last glyph");
  a_full_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && emit_c && full_c) |=> done_q)
    else $error("table full without parser stop");
`endif

endmodule

`default_nettype wire

// ===== design/bitmap_font_text_parser_unit.sv =====
// bitmap font text parser, top level: front classifier, byte queue, back parser
// depends on bfp_pkg, bfp_front, bfp_queue, bfp_back
//
// usage
//   s_axis carries the font text, one byte per beat; tuser set on a beat
//   restarts the parser with that byte as the first of a new font.
//   m_axis carries parsed fields: tuser is the field kind, tdata holds the
//   value, glyph and row, tlast marks the row that completes the last glyph.
//   a byte accepted on s_axis is written into the byte queue, then popped
//   by the parser, whose output register holds its result beat (if any).
//   throughput is one byte per cycle unless the m_axis receiver stalls;
//   the parser computes each byte's update combinationally (one
//   multiply-by-ten add and saturation for numbers).
//   when the m_axis receiver stalls, the parser holds its result beat and
//   stops taking bytes; the two-entry queue absorbs in-flight bytes and
//   s_axis_tready_o drops once it is full.
//   after reset the parser waits for the first token of a line; no clearing
//   pass is needed and bytes are taken from the first cycle.
`default_nettype none

module bitmap_font_text_parser_unit #(
  parameter int MAX_GLYPHS = 128,
  parameter int MAX_ROWS   = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  wire logic        s_axis_tuser_i,   // [0] start_of_font
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // [31:0] field_value, [38:32] glyph_index,
                                             // [43:39] row_index, [47:44] zero
  output logic [3:0]       m_axis_tuser_o,   // [3:0] field_kind
  output logic             m_axis_tlast_o    // table_full
);
  import bfp_pkg::*;

  bfp_item_t   front_item;
  bfp_item_t   back_item;
  logic        back_valid;
  logic        back_ready;
  logic [31:0] res_value;
  logic [6:0]  res_glyph;
  logic [4:0]  res_row;

  bfp_front u_front (
    .text_byte_i (s_axis_tdata_i),
    .start_i     (s_axis_tuser_i),
    .item_o      (front_item)
  );

  bfp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (s_axis_tvalid_i),
    .wr_ready_o (s_axis_tready_o),
    .wr_item_i  (front_item),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready),
    .rd_item_o  (back_item)
  );

  bfp_back #(
    .MAX_GLYPHS (MAX_GLYPHS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .item_i       (back_item),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_kind_o   (m_axis_tuser_o),
    .res_value_o  (res_value),
    .res_glyph_o  (res_glyph),
    .res_row_o    (res_row),
    .res_full_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'b0, res_row, res_glyph, res_value};

endmodule

`default_nettype wire

// ===== sim/bitmap_font_text_parser_checker.sv =====
// font text parser checker: predicts the field beats from the accepted text bytes
// and compares each output beat in order; depends on bfp_pkg for kinds and modes
`timescale 1ns / 1ps

module bitmap_font_text_parser_checker #(
  parameter int MAX_GLYPHS = 128,
  parameter int MAX_ROWS   = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [7:0]  s_axis_tdata_i,
  input  wire logic        s_axis_tuser_i,
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [47:0] m_axis_tdata_i,
  input  wire logic [3:0]  m_axis_tuser_i,
  input  wire logic        m_axis_tlast_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               fields_seen_o,
  output int               rows_seen_o,
  output int               full_seen_o
);
  import bfp_pkg::*;

  typedef struct packed {
    field_kind_e kind;
    logic [31:0] value;
    logic [6:0]  glyph;
    logic [4:0]  row;
    logic        full;
  } field_beat_t;

  localparam logic [8*15-1:0] WORD_SIZE   = "SIZE";
  localparam logic [8*15-1:0] WORD_BOX    = "FONTBOUNDINGBOX";
  localparam logic [8*15-1:0] WORD_BITMAP = "BITMAP";
  localparam int LEN_SIZE   = 4;
  localparam int LEN_BOX    = 15;
  localparam int LEN_BITMAP = 6;
  localparam int TOKEN_CAP  = 31;
  localparam int REPORT_CAP = 10;
  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  field_beat_t expected_fields_q[$];

  parse_mode_e mode;
  logic [2:0]  live_kw;
  logic [4:0]  tok_len;
  logic [31:0] magnitude;
  logic        negative;
  field_kind_e field_pos;
  logic [6:0]  rows_per_glyph;
  logic [6:0]  row_count;
  logic [8:0]  glyph_count;
  logic [3:0]  hi_nibble;
  logic        hi_bad;
  logic        done;

  int fails;
  int fields_seen;
  int rows_seen;
  int full_seen;

  function automatic logic word_char(input logic [8*15-1:0] word, input int len,
                                     input logic [4:0] pos, input logic [7:0] c);
    if (int'(pos) >= len) begin
      return 1'b0;
    end
    return word[8*(len - 1 - int'(pos)) +: 8] == c;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return {1'b1, 4'(c - "0")};
    end
    if (c >= "A" && c <= "F") begin
      return {1'b1, 4'(c - "A" + 8'd10)};
    end
    return 5'd0;
  endfunction

  task automatic clear_parser();
    mode           = M_TOKEN;
    live_kw        = '1;
    tok_len        = '0;
    magnitude      = '0;
    negative       = 1'b0;
    field_pos      = KIND_PT_SIZE;
    rows_per_glyph = '0;
    row_count      = '0;
    glyph_count    = '0;
    hi_nibble      = '0;
    hi_bad         = 1'b0;
    done           = 1'b0;
  endtask

  task automatic new_line();
    mode    = M_TOKEN;
    live_kw = '1;
    tok_len = '0;
  endtask

  task automatic start_number();
    mode      = M_NUM;
    magnitude = '0;
    negative  = 1'b0;
    tok_len   = '0;
  endtask

  task automatic close_glyph(output logic last);
    if (glyph_count >= MAX_GLYPHS - 1) begin
      done = 1'b1;
      last = 1'b1;
    end else begin
      glyph_count++;
      last = 1'b0;
    end
  endtask

  task automatic note_field(input field_kind_e kind, input logic [31:0] value,
                            input logic [6:0] glyph, input logic [4:0] row,
                            input logic full);
    expected_fields_q.push_back('{kind: kind, value: value, glyph: glyph, row: row,
                                  full: full});
  endtask

  task automatic advance_parser(input logic [7:0] c, input logic sof);
    logic        is_num;
    logic        full;
    logic [2:0]  next_live;
    logic [7:0]  digit;
    logic [63:0] wide;
    logic [31:0] value;
    logic [4:0]  hd;
    logic [4:0]  row_at;
    logic [6:0]  glyph_at;
    field_kind_e kind;
    if (sof) begin
      clear_parser();
    end
    if (done) begin
      return;
    end
    is_num = (c >= "0" && c <= "9") || c == ChMinus;
    case (mode)
      M_TOKEN: begin
        if (c == ChSpace || c == ChNewline) begin
          if (live_kw[KW_SIZE] && tok_len == LEN_SIZE) begin
            field_pos = KIND_PT_SIZE;
            start_number();
          end else if (live_kw[KW_BOX] && tok_len == LEN_BOX) begin
            field_pos = KIND_BOX_W;
            start_number();
          end else if (live_kw[KW_BITMAP] && tok_len == LEN_BITMAP) begin
            row_count = '0;
            if (rows_per_glyph == 0) begin
              close_glyph(full);
              mode = M_SKIP;
            end else begin
              mode = M_ROW_HI;
            end
          end else if (c == ChNewline) begin
            new_line();
          end else begin
            mode = M_SKIP;
          end
        end else begin
          next_live[KW_SIZE]   = live_kw[KW_SIZE] && word_char(WORD_SIZE, LEN_SIZE, tok_len, c);
          next_live[KW_BOX]    = live_kw[KW_BOX] && word_char(WORD_BOX, LEN_BOX, tok_len, c);
          next_live[KW_BITMAP] = live_kw[KW_BITMAP] &&
                                 word_char(WORD_BITMAP, LEN_BITMAP, tok_len, c);
          live_kw = next_live;
          if (tok_len < TOKEN_CAP) begin
            tok_len++;
          end
        end
      end
      M_NUM, M_NUM_TAIL: begin
        if (is_num) begin
          if (mode == M_NUM) begin
            if (c == ChMinus) begin
              if (tok_len == 0) begin
                negative = 1'b1;
              end else begin
                mode = M_NUM_TAIL;
              end
            end else begin
              digit     = c - "0";
              wide      = 64'(magnitude) * 64'd10 + 64'(digit);
              magnitude = (wide > 64'(MAG_CAP)) ? MAG_CAP : wide[31:0];
            end
          end
          if (tok_len < TOKEN_CAP) begin
            tok_len++;
          end
        end else begin
          kind  = field_pos;
          value = negative ? -magnitude : ((magnitude > POS_MAX) ? POS_MAX : magnitude);
          if (kind == KIND_PT_SIZE) begin
            if (negative && magnitude != 0) begin
              rows_per_glyph = 7'(MAX_ROWS);
            end else if (magnitude > MAX_ROWS) begin
              rows_per_glyph = 7'(MAX_ROWS);
            end else begin
              rows_per_glyph = magnitude[6:0];
            end
          end
          note_field(kind, value, '0, '0, 1'b0);
          if (kind == KIND_DPI_Y || kind == KIND_BOX_Y) begin
            if (c == ChNewline) begin
              new_line();
            end else begin
              mode = M_SKIP;
            end
          end else begin
            field_pos = field_kind_e'(field_pos + 1);
            start_number();
          end
        end
      end
      M_ROW_HI: begin
        hd        = hex_digit(c);
        hi_bad    = !hd[4];
        hi_nibble = hd[4] ? hd[3:0] : 4'd0;
        mode      = M_ROW_LO;
      end
      M_ROW_LO: begin
        hd       = hex_digit(c);
        row_at   = row_count[4:0];
        glyph_at = glyph_count[6:0];
        full     = 1'b0;
        row_count++;
        if (row_count >= rows_per_glyph) begin
          close_glyph(full);
        end
        if (hi_bad || !hd[4]) begin
          note_field(KIND_BAD_HEX, '0, glyph_at, row_at, full);
        end else begin
          note_field(KIND_ROW, {24'd0, hi_nibble, hd[3:0]}, glyph_at, row_at, full);
        end
        mode = M_ROW_SEP;
      end
      M_ROW_SEP: begin
        mode = (row_count >= rows_per_glyph) ? M_SKIP : M_ROW_HI;
      end
      default: begin
        if (c == ChNewline) begin
          new_line();
        end else begin
          mode = M_SKIP;
        end
      end
    endcase
  endtask

  task automatic check_field_beat();
    field_beat_t want;
    logic [47:0] want_data;
    fields_seen++;
    if (m_axis_tuser_i == KIND_ROW || m_axis_tuser_i == KIND_BAD_HEX) begin
      rows_seen++;
    end
    if (m_axis_tlast_i) begin
      full_seen++;
    end
    if (expected_fields_q.size() == 0) begin
      fails++;
      if (fails <= REPORT_CAP) begin
        $display("%0t: unexpected beat kind %0d data %h last %0b", $realtime,
                 m_axis_tuser_i, m_axis_tdata_i, m_axis_tlast_i);
      end
      return;
    end
    want      = expected_fields_q.pop_front();
    want_data = {4'd0, want.row, want.glyph, want.value};
    if (m_axis_tuser_i !== want.kind || m_axis_tdata_i !== want_data ||
        m_axis_tlast_i !== want.full) begin
      fails++;
      if (fails <= REPORT_CAP) begin
        $display("%0t: field mismatch, expected kind %0d value %0d glyph %0d row %0d last %0b",
                 $realtime, want.kind, $signed(want.value), want.glyph, want.row, want.full);
        $display("%0t:                 got kind %0d value %0d glyph %0d row %0d last %0b pad %h",
                 $realtime, m_axis_tuser_i, $signed(m_axis_tdata_i[31:0]),
                 m_axis_tdata_i[38:32], m_axis_tdata_i[43:39], m_axis_tlast_i,
                 m_axis_tdata_i[47:44]);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      expected_fields_q.delete();
      fails         = 0;
      fields_seen   = 0;
      rows_seen     = 0;
      full_seen     = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
      fields_seen_o <= 0;
      rows_seen_o   <= 0;
      full_seen_o   <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_field_beat();
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        advance_parser(s_axis_tdata_i, s_axis_tuser_i);
      end
      fail_count_o  <= fails;
      pending_o     <= expected_fields_q.size();
      fields_seen_o <= fields_seen;
      rows_seen_o   <= rows_seen;
      full_seen_o   <= full_seen;
    end
  end

endmodule

// ===== sim/bitmap_font_text_parser_unit_tb.sv =====
// testbench top for the font text parser: builds font text streams (keyword lines,
// bitmaps, noise, a full glyph table) and gives the verdict; uses the checker module
`timescale 1ns / 1ps

module bitmap_font_text_parser_unit_tb;

  localparam int MAX_GLYPHS  = 128;
  localparam int MAX_ROWS    = 32;
  localparam int BYTE_TARGET = 1600;
  localparam int HOLD_CYCLES = 300;
  localparam int TIMEOUT_NS  = 10_000_000;

  logic        clk;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  int fail_count;
  int pending;
  int fields_seen;
  int rows_seen;
  int full_seen;

  int sent_bytes;
  int gen_rows;
  bit start_next;
  bit idle_on;
  bit quiet;
  bit hold_req;
  bit hold_done;
  bit table_filled;

  bitmap_font_text_parser_unit #(
    .MAX_GLYPHS(MAX_GLYPHS),
    .MAX_ROWS  (MAX_ROWS)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  bitmap_font_text_parser_checker #(
    .MAX_GLYPHS(MAX_GLYPHS),
    .MAX_ROWS  (MAX_ROWS)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i (m_tdata),
    .m_axis_tuser_i (m_tuser),
    .m_axis_tlast_i (m_tlast),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .fields_seen_o  (fields_seen),
    .rows_seen_o    (rows_seen),
    .full_seen_o    (full_seen)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic put_byte(input logic [7:0] c);
    if (sent_bytes > BYTE_TARGET * 7 / 8) begin
      idle_on = 1'b0;
    end
    if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= c;
    s_tuser    <= start_next;
    start_next = 1'b0;
    sent_bytes++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_byte(s[i]);
    end
  endtask

  function automatic logic [7:0] hex_char(input int k);
    return (k < 10) ? "0" + 8'(k) : "A" + 8'(k - 10);
  endfunction

  function automatic string random_number_text();
    int pick;
    pick = $urandom_range(0, 13);
    case (pick)
      0:       return "";
      1:       return "-";
      2:       return "-0";
      3:       return "2147483647";
      4:       return "-2147483648";
      5:       return "2147483648";
      6:       return $sformatf("%0d%0d", $urandom, $urandom);
      7:       return $sformatf("-%0d%0d", $urandom, $urandom);
      8:       return $sformatf("%0d-%0d", $urandom_range(0, 99), $urandom_range(0, 99));
      9:       return $sformatf("--%0d", $urandom_range(0, 9));
      10:      return $sformatf("%0d", $urandom);
      11:      return $sformatf("-%0d", $urandom);
      default: return $sformatf("%0d", $urandom_range(0, 300));
    endcase
  endfunction

  // anything but a digit or minus, mostly a space
  function automatic logic [7:0] gap_byte();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) begin
      return " ";
    end
    do begin
      b = 8'($urandom_range(0, 255));
    end while ((b >= "0" && b <= "9") || b == "-");
    return b;
  endfunction

  task automatic put_line_end();
    logic [7:0] b;
    b = gap_byte();
    if ($urandom_range(0, 2) != 0) begin
      b = "\n";
    end
    put_byte(b);
    if (b != "\n") begin
      repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range("0", "z")));
      put_byte("\n");
    end
  endtask

  task automatic put_size_line();
    int    pick;
    int    ps;
    string ps_text;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      ps = 0;
    end else if (pick <= 6) begin
      ps = $urandom_range(1, 4);
    end else if (pick == 7) begin
      case ($urandom_range(0, 2))
        0:       ps = MAX_ROWS;
        1:       ps = MAX_ROWS + $urandom_range(1, 200);
        default: ps = -$urandom_range(1, 9);
      endcase
    end
    if (pick >= 8) begin
      ps_text  = random_number_text();
      gen_rows = $urandom_range(0, 2);
    end else begin
      ps_text  = $sformatf("%0d", ps);
      gen_rows = (ps < 0 || ps > MAX_ROWS) ? MAX_ROWS : ps;
    end
    put_text("SIZE");
    put_byte(($urandom_range(0, 7) == 0) ? "\n" : " ");
    put_text(ps_text);
    put_byte(gap_byte());
    put_text(random_number_text());
    put_byte(gap_byte());
    put_text(random_number_text());
    put_line_end();
  endtask

  task automatic put_box_line();
    put_text("FONTBOUNDINGBOX ");
    repeat (3) begin
      put_text(random_number_text());
      put_byte(gap_byte());
    end
    put_text(random_number_text());
    put_line_end();
  endtask

  task automatic put_bitmap_line();
    put_text("BITMAP");
    put_byte(($urandom_range(0, 3) == 0) ? " " : "\n");
    for (int r = 0; r < gen_rows; r++) begin
      repeat (2) begin
        put_byte(($urandom_range(0, 9) != 0) ? hex_char($urandom_range(0, 15))
                                             : 8'($urandom_range(0, 255)));
      end
      put_byte(($urandom_range(0, 4) != 0) ? "\n" : 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 2) == 0) begin
      put_text("ENDCHAR");
    end
    put_byte("\n");
  endtask

  task automatic put_junk_line();
    case ($urandom_range(0, 10))
      0:       put_text("SIZ 1 2 3");
      1:       put_text("SIZES 4");
      2:       put_text("BITMAPS");
      3:       put_text("FONTBOUNDINGBO 1 2");
      4:       put_text("FONTBOUNDINGBOXX 9");
      5:       put_text("STARTCHAR A");
      6:       put_text(" SIZE 1 2 3");
      7:       put_text("");
      8:       repeat (40) put_byte("Q");
      9:       put_text("Size 3 4 5");
      default: repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range("A", "Z")));
    endcase
    put_byte("\n");
  endtask

  task automatic put_noise_line();
    repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
    put_byte("\n");
  endtask

  task automatic put_font();
    int pick;
    start_next = 1'b1;
    gen_rows   = 0;
    quiet      = ($urandom_range(0, 3) == 0);
    put_size_line();
    repeat ($urandom_range(3, 9)) begin
      pick = $urandom_range(0, 19);
      if (pick <= 4) begin
        put_size_line();
      end else if (pick <= 8) begin
        put_box_line();
      end else if (pick <= 14) begin
        put_bitmap_line();
      end else if (pick <= 17) begin
        put_junk_line();
      end else begin
        put_noise_line();
      end
    end
  endtask

  // every glyph but the last has no rows; the last one closes the table
  task automatic fill_table();
    start_next = 1'b1;
    quiet      = ($urandom_range(0, 1) == 0);
    put_text("SIZE 0 1 1\n");
    repeat (MAX_GLYPHS - 1) put_text("BITMAP\n\n");
    put_text("SIZE 1 0 0\nBITMAP\n");
    put_byte(hex_char($urandom_range(0, 15)));
    put_byte(hex_char($urandom_range(0, 15)));
    put_text("\n\nSIZE 5 5 5\nBITMAP\nAA\n");
  endtask

  // number-dense lines while the receiver holds off
  task automatic put_box_burst();
    start_next = 1'b1;
    quiet      = 1'b1;
    hold_req   = 1'b1;
    repeat (6) put_box_line();
  endtask

  initial begin
    rst_n        = 1'b0;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tuser      <= 1'b0;
    sent_bytes   = 0;
    gen_rows     = 0;
    start_next   = 1'b0;
    idle_on      = 1'b1;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    table_filled = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone minus, minus inside a number, one-row bitmap with a bad high digit
    start_next = 1'b1;
    put_text("SIZE 1 - -7-3\nBITMAP\nZ9_");

    while (sent_bytes < BYTE_TARGET) begin
      if (!hold_req && sent_bytes > 250) begin
        put_box_burst();
      end else if (!table_filled && sent_bytes > 500) begin
        fill_table();
        table_filled = 1'b1;
      end else begin
        put_font();
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d text bytes; checked %0d field beats, %0d of them bitmap rows, %0d table-full",
             sent_bytes, fields_seen, rows_seen, full_seen);
    $display("stream mixed keyword lines, odd numbers, bad hex, noise and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("[bitmap_font_text_parser_unit] OK");
    end else begin
      $display("[bitmap_font_text_parser_unit] ERROR");
    end
    $finish;
  end

  initial begin
    hold_done = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        m_tready  <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && !quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[bitmap_font_text_parser_unit] ERROR");
    $finish;
  end

endmodule
